@@ rtl/rhc_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

	// Degrees in one sixth of the hue circle and in the whole circle
	localparam int unsigned DEG_SIXTH      = 60;
	localparam int unsigned DEG_CIRCLE     = 360;
	// Integer bits of the hue angle (0..359) and bits of one sixth (0..60)
	localparam int unsigned HUE_INT_BITS   = 9;
	localparam int unsigned SIXTH_INT_BITS = 6;

	// Which component is the largest; ties go to red, then green
	typedef enum logic [1:0] {
		SECTOR_RED   = 2'b00,
		SECTOR_GREEN = 2'b01,
		SECTOR_BLUE  = 2'b10
	} sector_t;

	// Hue bookkeeping that rides along the divider chain
	typedef struct packed {
		sector_t sector;
		logic    neg;
	} tag_t;

endpackage

`default_nettype wire

@@ rtl/rhc_if.sv @@
// Valid/ready channel interfaces for RGB pixels in and HSV results out.
`default_nettype none

interface rhc_pixel_if #(
	parameter int unsigned COMPONENT_BITS = 8
);
	logic                      valid;
	logic                      ready;
	logic [COMPONENT_BITS-1:0] red;
	logic [COMPONENT_BITS-1:0] green;
	logic [COMPONENT_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if #(
	parameter int unsigned COMPONENT_BITS = 8,
	parameter int unsigned HUE_FRAC_BITS  = 4
);
	logic                                           valid;
	logic                                           ready;
	logic [rhc_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] hue;
	logic [COMPONENT_BITS-1:0]                      saturation;
	logic [COMPONENT_BITS-1:0]                      brightness;
	logic                                           hue_undefined;

	modport source (output valid, output hue, output saturation, output brightness,
		output hue_undefined, input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		input hue_undefined, output ready);
endinterface

`default_nettype wire

@@ rtl/rhc_front.sv @@
// Front stage: max, min, delta, hue sector and the two divider numerators.
`default_nettype none

module rhc_front #(
	parameter int unsigned COMPONENT_BITS = 8,
	parameter int unsigned HUE_FRAC_BITS  = 4,
	parameter int unsigned STEPS          = 12
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 adv,
	input  wire logic                                 valid_in,
	input  wire logic [COMPONENT_BITS-1:0]            red,
	input  wire logic [COMPONENT_BITS-1:0]            green,
	input  wire logic [COMPONENT_BITS-1:0]            blue,
	output logic                                      valid,
	output rhc_pkg::tag_t                             tag,
	output logic [1:0][COMPONENT_BITS-1:0]            div,
	output logic [1:0][COMPONENT_BITS-1:0]            rem,
	output logic [1:0][STEPS-1:0]                     low
);

	localparam int unsigned NW    = COMPONENT_BITS + STEPS;
	localparam int unsigned SIXTH = rhc_pkg::DEG_SIXTH << HUE_FRAC_BITS;

	logic [COMPONENT_BITS-1:0] hi, lo, delta, opa, opb, mag;
	logic                      neg;
	rhc_pkg::sector_t          sector;
	logic [NW-1:0]             sat_num, hue_num;

	logic                             valid_q;
	rhc_pkg::tag_t                    tag_q;
	logic [1:0][COMPONENT_BITS-1:0]   div_q, rem_q;
	logic [1:0][STEPS-1:0]            low_q;

	// Pick the largest component and the difference that sets the hue offset
	always_comb begin
		if (red >= green && red >= blue) begin
			sector = rhc_pkg::SECTOR_RED;
			hi     = red;
			opa    = green;
			opb    = blue;
		end else if (green >= blue) begin
			sector = rhc_pkg::SECTOR_GREEN;
			hi     = green;
			opa    = blue;
			opb    = red;
		end else begin
			sector = rhc_pkg::SECTOR_BLUE;
			hi     = blue;
			opa    = red;
			opb    = green;
		end
		lo = red;
		if (green < lo) begin
			lo = green;
		end
		if (blue < lo) begin
			lo = blue;
		end
		delta = hi - lo;
		neg   = opa < opb;
		mag   = neg ? (opb - opa) : (opa - opb);
	end

	// Numerators: full scale times delta, and magnitude times one sixth
	assign sat_num = (NW'(delta) << COMPONENT_BITS) - NW'(delta);
	assign hue_num = NW'(mag) * NW'(SIXTH);

	// Hold the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	// Load the divider operands; lane 0 is saturation, lane 1 is hue
	always_ff @(posedge clk) begin
		if (adv && valid_in) begin
			tag_q.sector <= sector;
			tag_q.neg    <= neg;
			div_q[0]     <= hi;
			div_q[1]     <= delta;
			rem_q[0]     <= sat_num[NW-1:STEPS];
			rem_q[1]     <= hue_num[NW-1:STEPS];
			low_q[0]     <= sat_num[STEPS-1:0];
			low_q[1]     <= hue_num[STEPS-1:0];
		end
	end

	assign valid = valid_q;
	assign tag   = tag_q;
	assign div   = div_q;
	assign rem   = rem_q;
	assign low   = low_q;

endmodule

`default_nettype wire

@@ rtl/rhc_div_cell.sv @@
// Divider cell: one restoring quotient bit for each of two lanes, registered.
`default_nettype none

module rhc_div_cell #(
	parameter int unsigned COMPONENT_BITS = 8,
	parameter int unsigned STEPS          = 12
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 adv,
	input  wire logic                                 valid_in,
	input  wire rhc_pkg::tag_t                        tag_in,
	input  wire logic [1:0][COMPONENT_BITS-1:0]       div_in,
	input  wire logic [1:0][COMPONENT_BITS-1:0]       rem_in,
	input  wire logic [1:0][STEPS-1:0]                low_in,
	output logic                                      valid,
	output rhc_pkg::tag_t                             tag,
	output logic [1:0][COMPONENT_BITS-1:0]            div,
	output logic [1:0][COMPONENT_BITS-1:0]            rem,
	output logic [1:0][STEPS-1:0]                     low
);

	logic [1:0][COMPONENT_BITS:0]     trial, trial_sub;
	logic [1:0]                       fits;
	logic [1:0][COMPONENT_BITS-1:0]   rem_nx;
	logic [1:0][STEPS-1:0]            low_nx;

	logic                             valid_q;
	rhc_pkg::tag_t                    tag_q;
	logic [1:0][COMPONENT_BITS-1:0]   div_q, rem_q;
	logic [1:0][STEPS-1:0]            low_q;

	// Shift in the next numerator bit, subtract the divisor where it fits
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial[l]     = {rem_in[l], low_in[l][STEPS-1]};
			trial_sub[l] = trial[l] - {1'b0, div_in[l]};
			fits[l]      = trial[l] >= {1'b0, div_in[l]};
			rem_nx[l]    = fits[l] ? trial_sub[l][COMPONENT_BITS-1:0]
				: trial[l][COMPONENT_BITS-1:0];
			low_nx[l]    = {low_in[l][STEPS-2:0], fits[l]};
		end
	end

	// Hold the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	// Advance the partial results to the next cell
	always_ff @(posedge clk) begin
		if (adv && valid_in) begin
			tag_q <= tag_in;
			div_q <= div_in;
			rem_q <= rem_nx;
			low_q <= low_nx;
		end
	end

	assign valid = valid_q;
	assign tag   = tag_q;
	assign div   = div_q;
	assign rem   = rem_q;
	assign low   = low_q;

	// The partial remainder stays below a nonzero divisor
	a_sat_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && div_q[0] != '0 |-> rem_q[0] < div_q[0])
		else $error("saturation lane remainder not below divisor");

	a_hue_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && div_q[1] != '0 |-> rem_q[1] < div_q[1])
		else $error("hue lane remainder not below divisor");

endmodule

`default_nettype wire

@@ rtl/rhc_back.sv @@
// Back stage: assemble hue and saturation from the quotients, output register.
`default_nettype none

module rhc_back #(
	parameter int unsigned COMPONENT_BITS = 8,
	parameter int unsigned HUE_FRAC_BITS  = 4,
	parameter int unsigned STEPS          = 12
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         adv,
	input  wire logic                                         valid_in,
	input  wire rhc_pkg::tag_t                                tag_in,
	input  wire logic [1:0][COMPONENT_BITS-1:0]               div_in,
	input  wire logic [1:0][STEPS-1:0]                        low_in,
	output logic                                              valid,
	output logic [rhc_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0]    hue,
	output logic [COMPONENT_BITS-1:0]                         saturation,
	output logic [COMPONENT_BITS-1:0]                         brightness,
	output logic                                              hue_undefined
);

	localparam int unsigned HW     = rhc_pkg::HUE_INT_BITS + HUE_FRAC_BITS;
	localparam int unsigned SIXTH  = rhc_pkg::DEG_SIXTH << HUE_FRAC_BITS;
	localparam int unsigned CIRCLE = rhc_pkg::DEG_CIRCLE << HUE_FRAC_BITS;

	logic [HW-1:0]             q_hue, base, hue_nx;
	logic [STEPS-1:0]          q_sat;
	logic [COMPONENT_BITS-1:0] sat_nx;

	logic                      valid_q;
	logic [HW-1:0]             hue_q;
	logic [COMPONENT_BITS-1:0] sat_q, bright_q;
	logic                      undef_q;

	assign q_hue = HW'(low_in[1]);
	assign q_sat = low_in[0];

	// Sector base angle
	always_comb begin
		case (tag_in.sector)
			rhc_pkg::SECTOR_GREEN: base = HW'(2 * SIXTH);
			rhc_pkg::SECTOR_BLUE:  base = HW'(4 * SIXTH);
			default:               base = '0;
		endcase
	end

	// Add or subtract the offset; wrap a negative red hue onto the circle
	always_comb begin
		if (div_in[1] == '0) begin
			hue_nx = '0;
		end else if (tag_in.neg) begin
			if (tag_in.sector == rhc_pkg::SECTOR_RED) begin
				hue_nx = (q_hue == '0) ? '0 : HW'(CIRCLE) - q_hue;
			end else begin
				hue_nx = base - q_hue;
			end
		end else begin
			hue_nx = base + q_hue;
		end
		sat_nx = (div_in[0] == '0) ? '0 : q_sat[COMPONENT_BITS-1:0];
	end

	// Hold the valid bit of the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	// Load the finished item
	always_ff @(posedge clk) begin
		if (adv && valid_in) begin
			hue_q    <= hue_nx;
			sat_q    <= sat_nx;
			bright_q <= div_in[0];
			undef_q  <= div_in[0] == '0;
		end
	end

	assign valid         = valid_q;
	assign hue           = hue_q;
	assign saturation    = sat_q;
	assign brightness    = bright_q;
	assign hue_undefined = undef_q;

endmodule

`default_nettype wire

@@ rtl/rgb_to_hsv_converter.sv @@
// Pipeline: the front register, STEPS divider cells and the output register, where STEPS =
//   max(COMPONENT_BITS, HUE_FRAC_BITS + 6).
// Throughput: one item per cycle while the chain is not stalled; a row of STEPS divider cells, one quotient
//   bit each for saturation and hue, sits between the front and output registers.
// The whole chain stalls only while a result waits and the sink is not ready.
// Reset clears the valid bits of every stage; payload registers are not reset.
`default_nettype none

module rgb_to_hsv_converter #(
	parameter int unsigned COMPONENT_BITS = 8,
	parameter int unsigned HUE_FRAC_BITS  = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rhc_pixel_if.sink  pixel,
	rhc_hsv_if.source  hsv
);

	localparam int unsigned HUE_STEPS = HUE_FRAC_BITS + rhc_pkg::SIXTH_INT_BITS;
	localparam int unsigned STEPS     = (COMPONENT_BITS > HUE_STEPS) ? COMPONENT_BITS
		: HUE_STEPS;
	localparam int unsigned HW        = rhc_pkg::HUE_INT_BITS + HUE_FRAC_BITS;
	localparam int unsigned CIRCLE    = rhc_pkg::DEG_CIRCLE << HUE_FRAC_BITS;

	logic                              adv;
	logic                              out_valid;
	logic                              chain_valid [STEPS+1];
	rhc_pkg::tag_t                     chain_tag   [STEPS+1];
	logic [1:0][COMPONENT_BITS-1:0]    chain_div   [STEPS+1];
	logic [1:0][COMPONENT_BITS-1:0]    chain_rem   [STEPS+1];
	logic [1:0][STEPS-1:0]             chain_low   [STEPS+1];

	// Advance everything unless a finished result is being held
	assign adv         = !out_valid || hsv.ready;
	assign pixel.ready = adv;

	rhc_front #(
		.COMPONENT_BITS (COMPONENT_BITS),
		.HUE_FRAC_BITS  (HUE_FRAC_BITS),
		.STEPS          (STEPS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_in (pixel.valid),
		.red      (pixel.red),
		.green    (pixel.green),
		.blue     (pixel.blue),
		.valid    (chain_valid[0]),
		.tag      (chain_tag[0]),
		.div      (chain_div[0]),
		.rem      (chain_rem[0]),
		.low      (chain_low[0])
	);

	// Row of divider cells
	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		rhc_div_cell #(
			.COMPONENT_BITS (COMPONENT_BITS),
			.STEPS          (STEPS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (chain_valid[i]),
			.tag_in   (chain_tag[i]),
			.div_in   (chain_div[i]),
			.rem_in   (chain_rem[i]),
			.low_in   (chain_low[i]),
			.valid    (chain_valid[i+1]),
			.tag      (chain_tag[i+1]),
			.div      (chain_div[i+1]),
			.rem      (chain_rem[i+1]),
			.low      (chain_low[i+1])
		);
	end

	rhc_back #(
		.COMPONENT_BITS (COMPONENT_BITS),
		.HUE_FRAC_BITS  (HUE_FRAC_BITS),
		.STEPS          (STEPS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.valid_in      (chain_valid[STEPS]),
		.tag_in        (chain_tag[STEPS]),
		.div_in        (chain_div[STEPS]),
		.low_in        (chain_low[STEPS]),
		.valid         (out_valid),
		.hue           (hsv.hue),
		.saturation    (hsv.saturation),
		.brightness    (hsv.brightness),
		.hue_undefined (hsv.hue_undefined)
	);

	assign hsv.valid = out_valid;

	// Hue always lands inside the circle
	a_hue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hsv.hue < HW'(CIRCLE))
		else $error("hue outside the circle");

	// A black pixel gives zero hue and saturation
	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hsv.hue_undefined |->
			hsv.brightness == '0 && hsv.saturation == '0 && hsv.hue == '0)
		else $error("black pixel with nonzero hue or saturation");

	// Hue is defined exactly when some component is nonzero
	a_defined_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hsv.hue_undefined |-> hsv.brightness != '0)
		else $error("defined hue with zero brightness");

endmodule

`default_nettype wire
